/* rtl/ps2mct_pkg.sv */
// Package for the PS/2 mouse packet cursor tracker.
// Shared types, field positions, reset values and register indexes; no dependencies.
`timescale 1ns / 1ps

package ps2mct_pkg;

  localparam int BYTE_W         = 8;
  localparam int SIZE_W         = 14;
  localparam int COORD_BITS_DEF = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int QUEUE_DEPTH    = 2;

  // Flag byte bit positions
  localparam int SYNC_BIT   = 3;
  localparam int X_SIGN_BIT = 4;
  localparam int Y_SIGN_BIT = 5;
  localparam int LEFT_BIT   = 0;
  localparam int RIGHT_BIT  = 1;
  localparam int MIDDLE_BIT = 2;

  localparam int RESET_WIDTH  = 1024;
  localparam int RESET_HEIGHT = 768;
  localparam int RESET_POS_X  = 512;
  localparam int RESET_POS_Y  = 384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1
  } cfg_idx_t;

  // Byte position inside a packet
  typedef enum logic [1:0] {
    POS_FLAG  = 2'd0,
    POS_XDATA = 2'd1,
    POS_YDATA = 2'd2
  } byte_pos_t;

  typedef struct packed {
    logic [BYTE_W-1:0] flag_byte;
    logic [BYTE_W-1:0] x_byte;
    logic [BYTE_W-1:0] y_byte;
  } packet_t;

endpackage

/* rtl/ps2mct_front.sv */
// Packet assembler: gathers raw mouse bytes into 3-byte packets, drops bad sync bytes.
// Depends on ps2mct_pkg.
`timescale 1ns / 1ps

module ps2mct_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ps2mct_pkg::BYTE_W-1:0] in_mouse_byte,
  output logic                       push_valid,
  input  logic                       push_ready,
  output ps2mct_pkg::packet_t        push_data
);

  ps2mct_pkg::byte_pos_t state_r, state_nxt;
  logic [ps2mct_pkg::BYTE_W-1:0] flag_r, flag_nxt;
  logic [ps2mct_pkg::BYTE_W-1:0] xbyte_r, xbyte_nxt;
  logic accept;

  assign accept = in_valid && in_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    flag_nxt  = flag_r;
    xbyte_nxt = xbyte_r;
    if (accept) begin
      unique case (state_r)
        ps2mct_pkg::POS_XDATA: begin
          xbyte_nxt = in_mouse_byte;
          state_nxt = ps2mct_pkg::POS_YDATA;
        end
        ps2mct_pkg::POS_YDATA: begin
          state_nxt = ps2mct_pkg::POS_FLAG;
        end
        default: begin
          if (in_mouse_byte[ps2mct_pkg::SYNC_BIT]) begin
            flag_nxt  = in_mouse_byte;
            state_nxt = ps2mct_pkg::POS_XDATA;
          end else begin
            state_nxt = ps2mct_pkg::POS_FLAG;
          end
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    in_ready   = (state_r != ps2mct_pkg::POS_YDATA) || push_ready;
    push_valid = in_valid && (state_r == ps2mct_pkg::POS_YDATA);
    push_data.flag_byte = flag_r;
    push_data.x_byte    = xbyte_r;
    push_data.y_byte    = in_mouse_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ps2mct_pkg::POS_FLAG;
      flag_r  <= '0;
      xbyte_r <= '0;
    end else begin
      state_r <= state_nxt;
      flag_r  <= flag_nxt;
      xbyte_r <= xbyte_nxt;
    end
  end

endmodule

/* rtl/ps2mct_queue.sv */
// Short packet queue between assembler and cursor update.
// Depends on ps2mct_pkg.
`timescale 1ns / 1ps

module ps2mct_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  ps2mct_pkg::packet_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output ps2mct_pkg::packet_t pop_data
);

  localparam int DEPTH = ps2mct_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ps2mct_pkg::packet_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/ps2mct_back.sv */
// Cursor update: applies packet deltas, clamps to screen limits, holds the result register.
// Depends on ps2mct_pkg.
`timescale 1ns / 1ps

module ps2mct_back #(
  parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ps2mct_pkg::SIZE_W-1:0] cfg_data,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  ps2mct_pkg::packet_t           pop_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_BITS-1:0]         out_cursor_x,
  output logic [COORD_BITS-1:0]         out_cursor_y,
  output logic                          out_left_pressed,
  output logic                          out_right_pressed,
  output logic                          out_middle_pressed
);

  localparam int SUM_W = (COORD_BITS + 2 > ps2mct_pkg::SIZE_W + 1) ?
                         COORD_BITS + 2 : ps2mct_pkg::SIZE_W + 1;

  // Largest coordinate for a screen size: size-1, zero for size 0, capped at the coord range
  function automatic logic [COORD_BITS-1:0] limit_of(input logic [ps2mct_pkg::SIZE_W-1:0] size);
    logic [SUM_W-1:0] lim;
    logic [SUM_W-1:0] cap;
    lim = (size == '0) ? '0 : SUM_W'(size - 1'b1);
    cap = {{(SUM_W-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};
    if (lim > cap) begin
      lim = cap;
    end
    return lim[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SUM_W-1:0] v,
                                                   input logic [COORD_BITS-1:0] lim);
    logic signed [SUM_W-1:0] lim_s;
    logic [COORD_BITS-1:0]   res;
    lim_s = $signed({{(SUM_W-COORD_BITS){1'b0}}, lim});
    if (v < 0) begin
      res = '0;
    end else if (v > lim_s) begin
      res = lim;
    end else begin
      res = v[COORD_BITS-1:0];
    end
    return res;
  endfunction

  logic [COORD_BITS-1:0] lim_x_r, lim_y_r;
  logic [COORD_BITS-1:0] pos_x_r, pos_y_r, pos_x_nxt, pos_y_nxt;
  logic                  out_valid_r;
  logic [2:0]            buttons_r;
  logic                  do_pop;
  logic signed [8:0]     dx, dy;
  logic signed [SUM_W-1:0] sum_x, sum_y;

  assign pop_ready = !out_valid_r || out_ready;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    dx = $signed({pop_data.flag_byte[ps2mct_pkg::X_SIGN_BIT], pop_data.x_byte});
    dy = $signed({pop_data.flag_byte[ps2mct_pkg::Y_SIGN_BIT], pop_data.y_byte});
    sum_x = $signed({{(SUM_W-COORD_BITS){1'b0}}, pos_x_r}) + {{(SUM_W-9){dx[8]}}, dx};
    sum_y = $signed({{(SUM_W-COORD_BITS){1'b0}}, pos_y_r}) - {{(SUM_W-9){dy[8]}}, dy};
    pos_x_nxt = clamp(sum_x, lim_x_r);
    pos_y_nxt = clamp(sum_y, lim_y_r);
  end

  // Limits are recomputed on a register write; the user must write them only while idle, the block does not check it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_x_r <= limit_of(ps2mct_pkg::SIZE_W'(ps2mct_pkg::RESET_WIDTH));
      lim_y_r <= limit_of(ps2mct_pkg::SIZE_W'(ps2mct_pkg::RESET_HEIGHT));
    end else if (cfg_valid) begin
      if (cfg_index == ps2mct_pkg::CFG_SCREEN_WIDTH) begin
        lim_x_r <= limit_of(cfg_data);
      end
      if (cfg_index == ps2mct_pkg::CFG_SCREEN_HEIGHT) begin
        lim_y_r <= limit_of(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= COORD_BITS'(ps2mct_pkg::RESET_POS_X);
      pos_y_r     <= COORD_BITS'(ps2mct_pkg::RESET_POS_Y);
      out_valid_r <= 1'b0;
    end else begin
      if (do_pop) begin
        pos_x_r     <= pos_x_nxt;
        pos_y_r     <= pos_y_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      buttons_r <= {pop_data.flag_byte[ps2mct_pkg::MIDDLE_BIT],
                    pop_data.flag_byte[ps2mct_pkg::RIGHT_BIT],
                    pop_data.flag_byte[ps2mct_pkg::LEFT_BIT]};
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cursor_x       = pos_x_r;
  assign out_cursor_y       = pos_y_r;
  assign out_left_pressed   = buttons_r[0];
  assign out_right_pressed  = buttons_r[1];
  assign out_middle_pressed = buttons_r[2];

endmodule

/* rtl/ps2_mouse_packet_cursor_tracker.sv */
// Top level of the PS/2 mouse packet cursor tracker.
// Depends on ps2mct_pkg, ps2mct_front, ps2mct_queue, ps2mct_back.
`timescale 1ns / 1ps

// Takes one raw PS/2 mouse byte per input transaction and builds standard
// 3-byte packets. A byte offered as a packet's first byte is dropped unless
// its sync bit (bit 3) is set, which resynchronizes a broken stream. On the
// third byte the 9-bit signed X/Y deltas (signs from bits 4/5 of the flag
// byte) move the kept cursor: X is added, Y subtracted (screen rows grow
// downward). Each axis is clamped to 0 .. size-1; a size of 0 pins the axis
// to 0 and sizes beyond the coordinate range pin it to the largest coordinate.
// One output transaction per complete packet carries the position and the
// left/right/middle button bits; first and second bytes produce nothing.
// Throughput: one byte per clock while in_ready is high. The front end (byte
// assembler) hands each packet to a 2-entry queue, and the back end does the
// add-and-clamp into an output register, one packet per clock while that
// register is empty or being read; loading it raises out_valid, and an output
// stall keeps later packets waiting in the queue.
// The output register plus the queue absorb back pressure; in_ready only drops
// when a third byte arrives and the queue is full. Config: index 0 is
// screen_width, index 1 screen_height (14 bits each, reset 1024 x 768);
// other indexes are ignored. cfg_ready is always high; write only while idle.
// The cursor starts at (512, 384) after reset.
module ps2_mouse_packet_cursor_tracker #(
  parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ps2mct_pkg::BYTE_W-1:0] in_mouse_byte,
  // cursor result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_BITS-1:0]         out_cursor_x,
  output logic [COORD_BITS-1:0]         out_cursor_y,
  output logic                          out_left_pressed,
  output logic                          out_right_pressed,
  output logic                          out_middle_pressed,
  // register write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ps2mct_pkg::SIZE_W-1:0] cfg_data
);

  logic                push_valid, push_ready;
  ps2mct_pkg::packet_t push_data;
  logic                pop_valid, pop_ready;
  ps2mct_pkg::packet_t pop_data;

  // Writes are never back-pressured
  assign cfg_ready = 1'b1;

  ps2mct_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mouse_byte (in_mouse_byte),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  ps2mct_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ps2mct_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_data           (pop_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cursor_x       (out_cursor_x),
    .out_cursor_y       (out_cursor_y),
    .out_left_pressed   (out_left_pressed),
    .out_right_pressed  (out_right_pressed),
    .out_middle_pressed (out_middle_pressed)
  );

endmodule

/* test/ps2mct_cursor_checker.sv */
// Scoreboard for the PS/2 mouse packet cursor tracker: watches all three channels,
// predicts each cursor result and compares it. Depends on ps2mct_pkg only.
`timescale 1ns / 1ps

module ps2mct_cursor_checker
  import ps2mct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_mouse_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [COORD_BITS-1:0] out_cursor_x,
  input  logic [COORD_BITS-1:0] out_cursor_y,
  input  logic                  out_left_pressed,
  input  logic                  out_right_pressed,
  input  logic                  out_middle_pressed,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data,
  output int                    mismatch_count,
  output int                    cursor_checked,
  output int                    cursor_pending
);

  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int SIGN_WEIGHT = 256;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  left;
    logic                  right;
    logic                  middle;
  } cursor_t;

  logic [SIZE_W-1:0]     screen_w;
  logic [SIZE_W-1:0]     screen_h;
  byte_pos_t             slot;
  logic [BYTE_W-1:0]     held_flag;
  logic [BYTE_W-1:0]     held_xbyte;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  cursor_t               cursor_due[$];
  int                    fail_tally;
  int                    seen_tally;

  initial begin
    mismatch_count = 0;
    cursor_checked = 0;
    cursor_pending = 0;
    fail_tally     = 0;
    seen_tally     = 0;
  end

  task automatic report_cursor(input string what, input int want_v, input int got_v);
    fail_tally++;
    if (fail_tally <= 40)
      $display("[%0t] cursor check: %s expected %0d got %0d", $time, what, want_v, got_v);
  endtask

  // size 0 pins the axis at 0; sizes past the coordinate range stop at COORD_MAX
  function automatic logic [COORD_BITS-1:0] clamp_to_screen(input int v,
                                                             input logic [SIZE_W-1:0] size);
    int lim;
    lim = (size == '0) ? 0 : int'(size) - 1;
    if (lim > COORD_MAX) lim = COORD_MAX;
    if (v < 0) v = 0;
    if (v > lim) v = lim;
    return COORD_BITS'(v);
  endfunction

  function automatic bit track_mouse_byte(input logic [BYTE_W-1:0] b, output cursor_t r);
    int dx;
    int dy;
    r = '0;
    case (slot)
      POS_XDATA: begin
        held_xbyte = b;
        slot = POS_YDATA;
        return 1'b0;
      end
      POS_YDATA: begin
        slot = POS_FLAG;
        dx = int'(held_xbyte);
        dy = int'(b);
        if (held_flag[X_SIGN_BIT]) dx -= SIGN_WEIGHT;
        if (held_flag[Y_SIGN_BIT]) dy -= SIGN_WEIGHT;
        cur_x = clamp_to_screen(int'(cur_x) + dx, screen_w);
        cur_y = clamp_to_screen(int'(cur_y) - dy, screen_h);
        r.x      = cur_x;
        r.y      = cur_y;
        r.left   = held_flag[LEFT_BIT];
        r.right  = held_flag[RIGHT_BIT];
        r.middle = held_flag[MIDDLE_BIT];
        return 1'b1;
      end
      default: begin
        // no sync bit: drop it and keep hunting for a flag byte
        if (!b[SYNC_BIT]) begin
          slot = POS_FLAG;
          return 1'b0;
        end
        held_flag = b;
        slot = POS_XDATA;
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    cursor_t want;
    cursor_t fresh;
    if (!rst_n) begin
      screen_w   = SIZE_W'(RESET_WIDTH);
      screen_h   = SIZE_W'(RESET_HEIGHT);
      slot       = POS_FLAG;
      held_flag  = '0;
      held_xbyte = '0;
      cur_x      = COORD_BITS'(RESET_POS_X);
      cur_y      = COORD_BITS'(RESET_POS_Y);
      cursor_due.delete();
    end else begin
      // results first: a result leaving now never comes from a byte taken now
      if (out_valid && out_ready) begin
        if (cursor_due.size() == 0) begin
          report_cursor("unexpected result, cursor_x", -1, out_cursor_x);
        end else begin
          want = cursor_due.pop_front();
          seen_tally++;
          if (out_cursor_x !== want.x) report_cursor("cursor_x", want.x, out_cursor_x);
          if (out_cursor_y !== want.y) report_cursor("cursor_y", want.y, out_cursor_y);
          if (out_left_pressed !== want.left)
            report_cursor("left_pressed", want.left, out_left_pressed);
          if (out_right_pressed !== want.right)
            report_cursor("right_pressed", want.right, out_right_pressed);
          if (out_middle_pressed !== want.middle)
            report_cursor("middle_pressed", want.middle, out_middle_pressed);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SCREEN_WIDTH:  screen_w = cfg_data;
          CFG_SCREEN_HEIGHT: screen_h = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (track_mouse_byte(in_mouse_byte, fresh)) cursor_due.push_back(fresh);
      end
    end
    mismatch_count <= fail_tally;
    cursor_checked <= seen_tally;
    cursor_pending <= cursor_due.size();
  end

endmodule

/* test/ps2_mouse_packet_cursor_tracker_tb.sv */
// Top of the cursor tracker testbench: clock, reset, byte and register stimulus,
// output back pressure and verdict. Depends on ps2mct_pkg, the DUT and ps2mct_cursor_checker.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_tracker_tb;
  import ps2mct_pkg::*;

  localparam int COORD_BITS     = COORD_BITS_DEF;
  localparam int ITEM_TARGET    = 1750;   // packet bytes; noise bytes are extra
  localparam int PHASES         = 8;
  localparam int SETTLE_CYCLES  = 8;      // result passes the queue and output register after the third byte
  localparam int LONG_HOLD      = 400;
  localparam int CYCLE_LIMIT    = 500000;

  // register indexes past the two real ones; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  // receiver back-pressure styles, one per stretch
  typedef enum int {
    DRAIN_FREE,
    DRAIN_COIN,
    DRAIN_EVERY4,
    DRAIN_MOSTLY
  } drain_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_mouse_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [COORD_BITS-1:0] out_cursor_x;
  logic [COORD_BITS-1:0] out_cursor_y;
  logic                  out_left_pressed;
  logic                  out_right_pressed;
  logic                  out_middle_pressed;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [SIZE_W-1:0]     cfg_data;

  int mismatch_count;
  int cursor_checked;
  int cursor_pending;

  int cycle_count   = 0;
  int items_sent    = 0;
  int noise_sent    = 0;
  int settings_done = 0;
  int holds_done    = 0;
  int burst_left    = 0;
  bit no_gaps       = 1'b0;
  bit long_hold_req = 1'b0;

  ps2_mouse_packet_cursor_tracker #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mouse_byte      (in_mouse_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cursor_x       (out_cursor_x),
    .out_cursor_y       (out_cursor_y),
    .out_left_pressed   (out_left_pressed),
    .out_right_pressed  (out_right_pressed),
    .out_middle_pressed (out_middle_pressed),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  ps2mct_cursor_checker #(
    .COORD_BITS(COORD_BITS)
  ) cursor_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mouse_byte      (in_mouse_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cursor_x       (out_cursor_x),
    .out_cursor_y       (out_cursor_y),
    .out_left_pressed   (out_left_pressed),
    .out_right_pressed  (out_right_pressed),
    .out_middle_pressed (out_middle_pressed),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatch_count     (mismatch_count),
    .cursor_checked     (cursor_checked),
    .cursor_pending     (cursor_pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results still owed", cycle_count,
               cursor_pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // One byte transaction. The sender runs in bursts of random length; between bursts
  // valid may drop for a random number of cycles. Valid is never lowered and raised in
  // the same step, and the payload holds until the byte is taken.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_mouse_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_packet(input logic [BYTE_W-1:0] flag, input logic [BYTE_W-1:0] xb,
                             input logic [BYTE_W-1:0] yb);
    send_byte(flag);
    send_byte(xb);
    send_byte(yb);
    items_sent += 3;
  endtask

  // One register transaction; valid stays up so back-to-back writes need no re-raise.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                                  input bit poke_spare);
    put_reg(CFG_SCREEN_WIDTH, w);
    put_reg(CFG_SCREEN_HEIGHT, h);
    if (poke_spare) begin
      put_reg(CFG_IDX_SPARE_LO, SIZE_W'($urandom));
      put_reg(CFG_IDX_SPARE_HI, SIZE_W'($urandom));
    end
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  // Stop offering bytes and let every owed result drain. The extra settle
  // cycles cover a packet still moving through the queue and back end.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cursor_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Delta bytes: a quarter land on the interesting edges, the rest are uniform.
  function automatic logic [BYTE_W-1:0] edge_or_random();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // Receiver: stretches of different stall styles, plus a long hold-off on request
  // that fills the output register and queue until in_ready drops.
  initial begin
    drain_mode_t mode;
    int          stretch;
    int          hold_left;
    int          tick;
    out_ready <= 1'b0;
    mode      = DRAIN_FREE;
    stretch   = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
        holds_done++;
      end
      if (stretch == 0) begin
        mode    = drain_mode_t'($urandom_range(0, 3));
        stretch = $urandom_range(16, 120);
      end
      stretch--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          DRAIN_FREE:   out_ready <= 1'b1;
          DRAIN_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
          DRAIN_EVERY4: out_ready <= (tick % 4 == 0);
          default:      out_ready <= ($urandom_range(0, 6) != 0);
        endcase
      end
    end
  end

  // Main stimulus
  initial begin
    logic [BYTE_W-1:0] flag;
    logic [BYTE_W-1:0] xb;
    logic [BYTE_W-1:0] yb;
    bit                drift_x;
    bit                drift_y;
    int                phase_goal;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_mouse_byte <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_SCREEN_WIDTH;
    cfg_data      <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset screen (1024 x 768, cursor at 512,384).
    send_packet(8'h08, 8'h00, 8'h00);   // no motion, no buttons
    send_byte(8'h00);                   // bad flag byte, dropped
    send_byte(8'hF7);                   // every bit but sync set, dropped
    send_packet(8'h0F, 8'hFF, 8'h00);   // all buttons, largest positive x
    send_packet(8'h0F, 8'hFF, 8'hFF);   // largest positive x and y
    send_packet(8'h09, 8'h7F, 8'hFF);   // x clamps at right edge, y at top
    send_packet(8'h3C, 8'h00, 8'h00);   // both signs, most negative deltas
    send_packet(8'h38, 8'h00, 8'h00);
    send_packet(8'h38, 8'h00, 8'h00);   // y clamps at bottom edge
    send_packet(8'h18, 8'h00, 8'h80);   // x clamps at left edge

    // Random phases, each with its own screen size. The extremes, zero size and
    // sizes wider than the coordinate range all get a phase.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0:       configure_screen(14'd8192, 14'd8192, 1'b0);
        1:       configure_screen(14'd1, 14'd1, 1'b1);
        2:       configure_screen(14'd0, 14'd0, 1'b0);
        3:       configure_screen(14'd16383, 14'd9000, 1'b0);
        4:       configure_screen(14'd640, 14'd480, 1'b1);
        5:       configure_screen(SIZE_W'($urandom_range(1, 8192)),
                                  SIZE_W'($urandom_range(1, 8192)), 1'b0);
        6:       configure_screen(SIZE_W'($urandom_range(1, 64)),
                                  SIZE_W'($urandom_range(1, 64)), 1'b0);
        default: configure_screen(SIZE_W'($urandom_range(0, 16383)),
                                  SIZE_W'($urandom_range(0, 16383)), 1'b1);
      endcase
      no_gaps = (ph == 4);
      if (ph == 2 || ph == 6) long_hold_req = 1'b1;
      drift_x = $urandom_range(0, 1);
      drift_y = $urandom_range(0, 1);
      phase_goal = items_sent + (ITEM_TARGET - items_sent) / (PHASES - ph);

      while (items_sent < phase_goal) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: a stray byte, or a flag with only one data byte behind it
          if ($urandom_range(0, 1) == 1) begin
            send_byte(BYTE_W'($urandom));
            noise_sent++;
          end else begin
            flag = BYTE_W'($urandom);
            flag[SYNC_BIT] = 1'b1;
            send_byte(flag);
            send_byte(BYTE_W'($urandom));
            noise_sent += 2;
          end
        end else begin
          flag = BYTE_W'($urandom);
          flag[SYNC_BIT] = 1'b1;
          if ($urandom_range(0, 1) == 1) begin
            // push steadily one way so the edges get hit on every screen
            flag[X_SIGN_BIT] = drift_x;
            flag[Y_SIGN_BIT] = drift_y;
            xb = drift_x ? BYTE_W'($urandom_range(0, 40)) : BYTE_W'($urandom_range(215, 255));
            yb = drift_y ? BYTE_W'($urandom_range(0, 40)) : BYTE_W'($urandom_range(215, 255));
          end else begin
            xb = edge_or_random();
            yb = edge_or_random();
          end
          send_packet(flag, xb, yb);
        end
      end
    end

    wait_drained();
    $display("Run covered %0d packet bytes and %0d noise bytes; %0d cursor results checked",
             items_sent, noise_sent, cursor_checked);
    $display("%0d screen settings applied, %0d long output hold-offs", settings_done,
             holds_done);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ps2mct_pkg.sv
rtl/ps2mct_front.sv
rtl/ps2mct_queue.sv
rtl/ps2mct_back.sv
rtl/ps2_mouse_packet_cursor_tracker.sv
test/ps2mct_cursor_checker.sv
test/ps2_mouse_packet_cursor_tracker_tb.sv
